// ===== sv/clnw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_pkg: shared types and constants of the character LCD nibble writer
// Request codes, register indexes, run descriptors and the init sequence.
// ----------------------------------------------------------------------------
package clnw_pkg;

    localparam int CfgDataW = 6;

    // Request codes.
    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_CHAR  = 2'd2;
    localparam logic [1:0] REQ_HOME  = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    // Configuration register indexes.
    localparam logic CFG_LINE_LENGTH = 1'b0;
    localparam logic CFG_BACKLIGHT   = 1'b1;

    // Timing values carried with each expander write.
    localparam logic [15:0] WAIT_POWER_UP = 16'd50000;
    localparam logic [13:0] WAIT_EN_HIGH  = 14'd1;
    localparam logic [13:0] WAIT_BASE     = 14'd100;
    localparam logic [13:0] WAIT_CLEAR    = 14'd2100;

    // Positions of the final write of each kind of run.
    localparam logic [4:0] LAST_POS_INIT  = 5'd27;
    localparam logic [4:0] LAST_POS_SHORT = 5'd3;
    localparam logic [4:0] LAST_POS_WRAP  = 5'd7;

    typedef enum logic [2:0] {
        RUN_INIT      = 3'd0,
        RUN_CLEAR     = 3'd1,
        RUN_HOME      = 3'd2,
        RUN_CHAR      = 3'd3,
        RUN_WRAP_CHAR = 3'd4
    } t_run_kind;

    typedef struct packed {
        t_run_kind  kind;
        logic [7:0] char_code;
        logic [3:0] addr_nibble;
    } t_run;

    typedef struct packed {
        logic [7:0]  expander_byte;
        logic [15:0] wait_before_us;
        logic [13:0] wait_after_us;
        logic        last;
    } t_write;

    // Nibbles of the power-up sequence: function set, three wake-ups,
    // 4-bit mode, function set, display on, clear, entry mode.
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        case (idx)
            4'd0:    nib = 4'h2;
            4'd1:    nib = 4'h8;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h3;
            4'd4:    nib = 4'h3;
            4'd5:    nib = 4'h2;
            4'd6:    nib = 4'h2;
            4'd7:    nib = 4'h8;
            4'd8:    nib = 4'h0;
            4'd9:    nib = 4'hC;
            4'd10:   nib = 4'h0;
            4'd11:   nib = 4'h1;
            4'd12:   nib = 4'h0;
            4'd13:   nib = 4'h6;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    // Wait after the enable-low write of each init nibble.
    function automatic logic [13:0] init_wait(input logic [3:0] idx);
        logic [13:0] w;
        case (idx)
            4'd1:    w = 14'd5100;
            4'd2:    w = 14'd5100;
            4'd3:    w = 14'd1100;
            4'd4:    w = 14'd10100;
            4'd11:   w = WAIT_CLEAR;
            default: w = WAIT_BASE;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/clnw_write_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_write_gen: expander write generator
// Maps a run descriptor and a position in the run to one expander write.
// ----------------------------------------------------------------------------
module clnw_write_gen (
    input  clnw_pkg::t_run   i_run,
    input  logic [4:0]       i_pos,
    input  logic             i_backlight,
    output clnw_pkg::t_write o_write
);
    import clnw_pkg::*;

    logic [3:0]  nib_idx;
    logic        phase_low;
    logic [3:0]  nib;
    logic        rs;
    logic [13:0] wait_low;
    logic [4:0]  last_pos;

    assign nib_idx   = i_pos[4:1];
    assign phase_low = i_pos[0];

    always_comb begin
        nib      = 4'h0;
        rs       = 1'b0;
        wait_low = WAIT_BASE;
        last_pos = LAST_POS_SHORT;
        case (i_run.kind)
            RUN_INIT: begin
                nib      = init_nibble(nib_idx);
                wait_low = init_wait(nib_idx);
                last_pos = LAST_POS_INIT;
            end
            RUN_CLEAR: begin
                nib      = nib_idx[0] ? 4'h1 : 4'h0;
                wait_low = nib_idx[0] ? WAIT_CLEAR : WAIT_BASE;
            end
            RUN_HOME: begin
                nib = nib_idx[0] ? 4'h0 : 4'h8;
            end
            RUN_CHAR: begin
                nib = nib_idx[0] ? i_run.char_code[3:0] : i_run.char_code[7:4];
                rs  = 1'b1;
            end
            RUN_WRAP_CHAR: begin
                // Set-address command for the new line, then the character.
                case (nib_idx[1:0])
                    2'd0:    nib = i_run.addr_nibble;
                    2'd1:    nib = 4'h0;
                    2'd2:    nib = i_run.char_code[7:4];
                    default: nib = i_run.char_code[3:0];
                endcase
                rs       = nib_idx[1];
                last_pos = LAST_POS_WRAP;
            end
            default: begin
                nib = 4'h0;
            end
        endcase
    end

    assign o_write.expander_byte  = {nib, i_backlight, ~phase_low, 1'b0, rs};
    assign o_write.wait_before_us = (i_run.kind == RUN_INIT && i_pos == 5'd0)
                                    ? WAIT_POWER_UP : 16'd0;
    assign o_write.wait_after_us  = phase_low ? wait_low : WAIT_EN_HIGH;
    assign o_write.last           = (i_pos == last_pos);

endmodule

// ===== sv/char_lcd_nibble_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit: character LCD request to expander byte writer
// Turns init, clear, character and home requests into expander writes for a
// 4-bit mode character display and keeps track of the cursor.
// ----------------------------------------------------------------------------
// A request becomes its expander writes, one per cycle while the output is
// taken: 28 for init, 4 for clear, home or newline, 4 for a character and 8
// for a character that first wraps to the next line. The pace is set by the
// write sequencer, whose position counter steps once per unstalled cycle into
// a single output register; the next request waits in the input register and
// its run starts in the cycle after the previous run's final write, so
// consecutive requests' writes follow with no gap while the output is taken.
module char_lcd_nibble_writer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [clnw_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_req_type,
    input  logic [7:0]                    i_char_code,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_expander_byte,
    output logic [15:0]                   o_wait_before_us,
    output logic [13:0]                   o_wait_after_us,
    output logic                          o_last
);
    import clnw_pkg::*;

    // Configuration.
    logic [5:0] r_line_length;
    logic       r_backlight;

    // Input register.
    logic       r_in_valid;
    logic [1:0] r_req;
    logic [7:0] r_char;

    // Run stage and cursor.
    logic       r_run_active;
    t_run       r_run, n_run;
    logic [4:0] r_pos;
    logic [5:0] r_col, n_col;
    logic       r_line, n_line;

    // Output register.
    logic       r_out_valid;
    t_write     r_out;

    t_write     gen_write;
    logic       gen_fire;
    logic       load_run;

    assign gen_fire   = r_run_active && (!r_out_valid || i_out_ready);
    assign load_run   = r_in_valid && (!r_run_active || (gen_fire && gen_write.last));
    assign o_in_ready = !r_in_valid || load_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= 6'd16;
            r_backlight   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_LENGTH: r_line_length <= i_cfg_data;
                CFG_BACKLIGHT:   r_backlight   <= i_cfg_data[0];
                default:         r_backlight   <= r_backlight;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req  <= i_req_type;
            r_char <= i_char_code;
        end
    end

    // Decode the waiting request and move the cursor as the run starts.
    always_comb begin
        n_run.char_code   = r_char;
        n_run.addr_nibble = 4'h8;
        n_col             = 6'd0;
        n_line            = 1'b0;
        case (r_req)
            REQ_INIT:  n_run.kind = RUN_INIT;
            REQ_CLEAR: n_run.kind = RUN_CLEAR;
            REQ_HOME:  n_run.kind = RUN_HOME;
            default: begin
                if (r_char == CHAR_NEWLINE) begin
                    n_run.kind = RUN_HOME;
                end else if (r_col >= r_line_length) begin
                    n_run.kind        = RUN_WRAP_CHAR;
                    n_line            = ~r_line;
                    n_col             = 6'd1;
                    n_run.addr_nibble = ~r_line ? 4'hC : 4'h8;
                end else begin
                    n_run.kind = RUN_CHAR;
                    n_line     = r_line;
                    n_col      = r_col + 6'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_active <= 1'b0;
            r_pos        <= 5'd0;
            r_col        <= 6'd0;
            r_line       <= 1'b0;
        end else if (load_run) begin
            r_run_active <= 1'b1;
            r_pos        <= 5'd0;
            r_col        <= n_col;
            r_line       <= n_line;
        end else if (gen_fire) begin
            r_run_active <= !gen_write.last;
            r_pos        <= r_pos + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_run) begin
            r_run <= n_run;
        end
    end

    clnw_write_gen u_write_gen (
        .i_run       (r_run),
        .i_pos       (r_pos),
        .i_backlight (r_backlight),
        .o_write     (gen_write)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (gen_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_fire) begin
            r_out <= gen_write;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_expander_byte  = r_out.expander_byte;
    assign o_wait_before_us = r_out.wait_before_us;
    assign o_wait_after_us  = r_out.wait_after_us;
    assign o_last           = r_out.last;

endmodule

// ===== sv/clnw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_checker: port-level checks of the character LCD nibble writer
// Watches the result channel for the enable pulse pattern and wait values.
// ----------------------------------------------------------------------------
module clnw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_expander_byte,
    input logic [15:0] o_wait_before_us,
    input logic [13:0] o_wait_after_us,
    input logic        o_last
);
    import clnw_pkg::*;

    logic out_xfer;
    assign out_xfer = o_out_valid && i_out_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_expander_byte))
        else $error("result changed or dropped while stalled");

    a_wait_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_expander_byte[2] ? o_wait_after_us == WAIT_EN_HIGH
                                            : o_wait_after_us >= WAIT_BASE))
        else $error("wait after does not match the enable phase");

    a_power_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wait_before_us != 16'd0
        |-> o_wait_before_us == WAIT_POWER_UP && o_expander_byte[2] && !o_last)
        else $error("power-up wait on a write other than the first");

    // The enable-low write follows its enable-high write at once.
    a_pulse_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_expander_byte[2]
        |=> o_out_valid && !o_expander_byte[2]
            && o_expander_byte[7:4] == $past(o_expander_byte[7:4]))
        else $error("enable-low write missing after an enable-high write");

    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> !o_expander_byte[2])
        else $error("transaction run ends on an enable-high write");

endmodule

bind char_lcd_nibble_writer_unit clnw_checker u_clnw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_expander_byte  (o_expander_byte),
    .o_wait_before_us (o_wait_before_us),
    .o_wait_after_us  (o_wait_after_us),
    .o_last           (o_last)
);
